// ===== src/rse_pkg.sv =====
package rse_pkg;

  // Operation codes of the command field. Codes above CMD_SKIP behave like a skip.
  typedef enum logic [4:0] {
    CMD_ADD  = 5'd0,
    CMD_SUB  = 5'd1,
    CMD_AND  = 5'd2,
    CMD_OR   = 5'd3,
    CMD_XOR  = 5'd4,
    CMD_SLT  = 5'd5,
    CMD_SLL  = 5'd6,
    CMD_SRA  = 5'd7,
    CMD_ADDI = 5'd8,
    CMD_ANDI = 5'd9,
    CMD_ORI  = 5'd10,
    CMD_XORI = 5'd11,
    CMD_SLTI = 5'd12,
    CMD_LW   = 5'd13,
    CMD_LB   = 5'd14,
    CMD_SW   = 5'd15,
    CMD_SB   = 5'd16,
    CMD_LUI  = 5'd17,
    CMD_SKIP = 5'd18
  } cmd_e;

  localparam int unsigned XLEN    = 32;
  localparam int unsigned REG_W   = 5;
  localparam int unsigned NUM_REG = 32;
  localparam int unsigned IMM_W   = 12;
  localparam int unsigned LANES   = 4;

  typedef struct packed {
    logic [4:0]             cmd;
    logic [REG_W-1:0]       dest_reg;
    logic [REG_W-1:0]       src1_reg;
    logic [REG_W-1:0]       src2_reg;
    logic signed [XLEN-1:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [REG_W-1:0]       written_reg;
    logic signed [XLEN-1:0] written_value;
    logic                   did_write;
  } out_item_t;

endpackage

// ===== src/rv32_subset_execute_top.sv =====
// Execute unit for a small subset of RV32I instructions.
//
// Channels: the input channel carries one decoded instruction per transfer
// (in_valid_i / in_ready_o / in_data_i); the output channel returns exactly one
// result per instruction (out_valid_o / out_ready_i / out_data_o), telling which
// register was written and with what value, in instruction order.
//
// Timing: the register file is read when an instruction is transferred. An ALU,
// lui or store result is registered from the execute state; a load reads the
// byte memory there and its result is registered from the load state. The next
// instruction is taken as soon as the previous one has finished. A finished
// result waits in the output register while the next instruction is taken in;
// that instruction completes once the output register is free, so a stalled
// receiver holds the block in place.
//
// Reset: the register file is marked all zero at once through per-register valid
// bits. The byte memory is cleared by a sweep over its MEM_BYTES/4 rows, one row of
// all four byte lanes per cycle, during which in_ready_o stays low.
// MEM_BYTES must be a power of two; addresses wrap at that size.
module rv32_subset_execute_top
  import rse_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned AddrW   = $clog2(MEM_BYTES);
  localparam int unsigned NumRows = MEM_BYTES / LANES;
  localparam int unsigned RowW    = $clog2(NumRows);

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_LOAD  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic              in_fire;
  logic              slot_free;
  logic              done;
  logic [RowW-1:0]   clr_cnt_q;
  logic              clr_last;

  // Latched instruction.
  logic [4:0]        cmd_q;
  logic [REG_W-1:0]  rd_q;
  logic [XLEN-1:0]   imm_q;

  // Register file: synchronous memory with two read ports and one write port.
  logic [XLEN-1:0]   rf_mem [NUM_REG];
  logic [NUM_REG-1:0] rf_vld_q;
  logic [XLEN-1:0]   rf_a_q, rf_b_q;
  logic              va_q, vb_q;
  logic [REG_W-1:0]  rd_addr_b;
  logic              rf_we;
  logic [XLEN-1:0]   op_a, op_b;

  // Execute datapath.
  logic [XLEN-1:0]   imm_ext;
  logic [XLEN-1:0]   mem_addr;
  logic [XLEN-1:0]   alu_res;
  logic [XLEN-1:0]   load_res;
  logic [XLEN-1:0]   fin_res;
  logic              is_load, writer;
  logic [1:0]        a_lo_q;

  // Byte memory lanes.
  logic [LANES-1:0]  bank_we;
  logic              bank_re;
  logic [RowW-1:0]   bank_row   [LANES];
  logic [7:0]        bank_wdata [LANES];
  logic [7:0]        bank_rdata [LANES];
  logic [7:0]        ld_byte    [LANES];

  out_item_t         out_q;
  logic              out_valid_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign clr_last   = (clr_cnt_q == RowW'(NumRows - 1));

  // Decode of the latched command.
  assign is_load  = (cmd_q == CMD_LW) || (cmd_q == CMD_LB);
  assign writer   = (cmd_q <= CMD_LB) || (cmd_q == CMD_LUI);

  // A load finishes in the load state, after the execute state; everything else finishes in the execute state.
  assign done = ((state_q == S_EXEC) && !is_load && slot_free) ||
                ((state_q == S_LOAD) && slot_free);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (is_load) begin
          state_d = S_LOAD;
        end else if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      S_LOAD: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Instruction latch; the payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= in_data_i.cmd;
      rd_q  <= in_data_i.dest_reg;
      imm_q <= in_data_i.immediate;
    end
    if (state_q == S_EXEC) a_lo_q <= mem_addr[1:0];
  end

  // Stores read their data register on the second port in place of src2.
  assign rd_addr_b = ((in_data_i.cmd == CMD_SW) || (in_data_i.cmd == CMD_SB)) ?
                     in_data_i.dest_reg : in_data_i.src2_reg;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rf_a_q <= rf_mem[in_data_i.src1_reg];
      rf_b_q <= rf_mem[rd_addr_b];
    end
    if (rf_we) rf_mem[rd_q] <= fin_res;
  end

  // Valid bits stand in for clearing the register file. Register 0 is never
  // marked valid, so it always reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
    end else begin
      if (in_fire) begin
        va_q <= rf_vld_q[in_data_i.src1_reg];
        vb_q <= rf_vld_q[rd_addr_b];
      end
      if (rf_we) rf_vld_q[rd_q] <= 1'b1;
    end
  end

  assign op_a = va_q ? rf_a_q : '0;
  assign op_b = vb_q ? rf_b_q : '0;

  assign rf_we = done && writer && (rd_q != '0);

  // ALU.
  assign imm_ext  = {{(XLEN - IMM_W){imm_q[IMM_W-1]}}, imm_q[IMM_W-1:0]};
  assign mem_addr = op_a + imm_ext;

  always_comb begin
    alu_res = '0;
    unique case (cmd_q)
      CMD_ADD:  alu_res = op_a + op_b;
      CMD_SUB:  alu_res = op_a - op_b;
      CMD_AND:  alu_res = op_a & op_b;
      CMD_OR:   alu_res = op_a | op_b;
      CMD_XOR:  alu_res = op_a ^ op_b;
      CMD_SLT:  alu_res = {{(XLEN - 1){1'b0}}, ($signed(op_a) < $signed(op_b))};
      CMD_SLL:  alu_res = op_a << op_b[4:0];
      CMD_SRA:  alu_res = $unsigned($signed(op_a) >>> op_b[4:0]);
      CMD_ADDI: alu_res = op_a + imm_ext;
      CMD_ANDI: alu_res = op_a & imm_ext;
      CMD_ORI:  alu_res = op_a | imm_ext;
      CMD_XORI: alu_res = op_a ^ imm_ext;
      CMD_SLTI: alu_res = {{(XLEN - 1){1'b0}}, ($signed(op_a) < $signed(imm_ext))};
      CMD_LUI:  alu_res = {imm_q[XLEN-IMM_W-1:0], {IMM_W{1'b0}}};
      default:  alu_res = '0;
    endcase
  end

  // Byte memory: four lanes, lane j holds the bytes whose address ends in j.
  // Each byte of an access wraps on its own, so every lane gets its own row.
  assign bank_re = (state_q == S_EXEC) && is_load;

  for (genvar j = 0; j < LANES; j++) begin : g_bank
    logic [1:0]       ofs;
    logic [AddrW-1:0] byte_addr;
    logic [7:0]       mem [NumRows];
    logic [7:0]       rdata_q;

    assign ofs       = 2'(j) - mem_addr[1:0];
    assign byte_addr = mem_addr[AddrW-1:0] + AddrW'(ofs);

    always_comb begin
      if (state_q == S_CLEAR) begin
        bank_row[j]   = clr_cnt_q;
        bank_we[j]    = 1'b1;
        bank_wdata[j] = '0;
      end else begin
        bank_row[j]   = byte_addr[AddrW-1:2];
        bank_we[j]    = (state_q == S_EXEC) && slot_free &&
                        ((cmd_q == CMD_SW) || ((cmd_q == CMD_SB) && (ofs == 2'd0)));
        bank_wdata[j] = op_b[8*ofs +: 8];
      end
    end

    always_ff @(posedge clk_i) begin
      if (bank_we[j]) mem[bank_row[j]] <= bank_wdata[j];
      if (bank_re) rdata_q <= mem[bank_row[j]];
    end

    assign bank_rdata[j] = rdata_q;
    // Byte j of the loaded word sits in the lane that the low address bits select.
    assign ld_byte[j]    = bank_rdata[2'(j) + a_lo_q];
  end

  assign load_res = (cmd_q == CMD_LB) ? {{(XLEN - 8){ld_byte[0][7]}}, ld_byte[0]} :
                    {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};

  assign fin_res = (state_q == S_LOAD) ? load_res : alu_res;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q.did_write     <= rf_we;
      out_q.written_reg   <= rf_we ? rd_q : '0;
      out_q.written_value <= rf_we ? fin_res : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_write_nonzero_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.did_write |-> out_data_o.written_reg != '0)
    else $error("reported write to register zero");

  a_no_write_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.did_write |->
      (out_data_o.written_reg == '0) && (out_data_o.written_value == '0))
    else $error("result without a write is not all zero");

  a_reg0_never_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rf_vld_q[0])
    else $error("register zero marked as written");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_EXEC)
    else $error("accepted instruction did not enter execute");

  a_no_store_while_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> bank_we == '0)
    else $error("byte memory written while idle");
`endif

endmodule
